[rtl/rldr_pkg.sv]
// Shared types and constants for the rule list DFA recognizer.
// No dependencies; imported by rldr_scan and the top level.
`timescale 1ns / 1ps

package rldr_pkg;

   localparam int RULE_DEPTH_DEF = 64;

   // request type codes
   localparam logic [1:0] REQ_LOAD   = 2'd0;
   localparam logic [1:0] REQ_SYMBOL = 2'd1;
   localparam logic [1:0] REQ_END    = 2'd2;

   localparam int ACCEPT_BIT = 7;

   typedef struct packed {
      logic [7:0] from_state;
      logic [7:0] symbol;
      logic [7:0] to_state;
   } rule_type;

   typedef struct packed {
      logic       start;
      logic [6:0] rule_count;
      logic [7:0] symbol;
      logic [7:0] cur_state;
   } scan_cmd_type;

   typedef struct packed {
      logic       done;
      logic       hit;
      logic [7:0] next_state;
   } scan_rsp_type;

endpackage

[rtl/rldr_scan.sv]
// Rule memory and the sequential scan engine that walks it for one symbol.
// Depends on rldr_pkg.
`timescale 1ns / 1ps

module rldr_scan #(
   parameter int RULE_DEPTH = rldr_pkg::RULE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  logic [5:0]            wr_index,
   input  rldr_pkg::rule_type    wr_rule,
   input  rldr_pkg::scan_cmd_type cmd,
   output rldr_pkg::scan_rsp_type rsp
);
   import rldr_pkg::*;

   localparam int AW  = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
   localparam int CW  = $clog2(RULE_DEPTH + 1);
   localparam int LW  = (CW > 7) ? CW : 7;
   localparam int XW0 = (AW > 6) ? AW : 6;
   localparam int XW  = XW0 + 1;

   typedef enum logic {S_IDLE, S_RUN} state_type;
   typedef enum logic {PH_FROM, PH_SYM} phase_type;

   rule_type  rule_mem [RULE_DEPTH];
   rule_type  rd_data_ff;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic [LW-1:0] idx_ff, idx_in;
   logic [LW-1:0] limit_ff, limit_in;
   logic          pend_ff, pend_in;
   logic [7:0]    sym_ff, sym_in;
   logic [7:0]    cur_ff, cur_in;
   logic          done_ff, done_in;
   logic          hit_ff, hit_in;
   logic [7:0]    next_ff, next_in;

   logic [XW-1:0] wr_idx_ext;
   logic          wr_in_range;
   logic [LW-1:0] count_ext;
   logic          from_hit, sym_hit, decided;

   assign wr_idx_ext  = XW'(wr_index);
   assign wr_in_range = wr_idx_ext < XW'(RULE_DEPTH);
   assign count_ext   = LW'(cmd.rule_count);

   always_ff @(posedge clock) begin
      if (wr_en && wr_in_range) begin
         rule_mem[wr_idx_ext[AW-1:0]] <= wr_rule;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= rule_mem[idx_ff[AW-1:0]];
   end

   assign from_hit = rd_data_ff.from_state == cur_ff;
   assign sym_hit  = rd_data_ff.symbol == sym_ff;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      idx_in   = idx_ff;
      limit_in = limit_ff;
      pend_in  = pend_ff;
      sym_in   = sym_ff;
      cur_in   = cur_ff;
      done_in  = 1'b0;
      hit_in   = hit_ff;
      next_in  = next_ff;
      decided  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (cmd.start) begin
               limit_in = (count_ext > LW'(RULE_DEPTH)) ? LW'(RULE_DEPTH) : count_ext;
               idx_in   = '0;
               pend_in  = 1'b0;
               phase_in = PH_FROM;
               sym_in   = cmd.symbol;
               cur_in   = cmd.cur_state;
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            // rd_data_ff holds entry idx_ff-1 when pend_ff is set
            if (pend_ff) begin
               if (phase_ff == PH_FROM) begin
                  if (from_hit) begin
                     if (sym_hit) begin
                        decided = 1'b1;
                        hit_in  = 1'b1;
                        next_in = rd_data_ff.to_state;
                     end else begin
                        phase_in = PH_SYM;
                     end
                  end
               end else if (sym_hit) begin
                  // a symbol match decides: a hit on a rule of this state, a reject on another
                  decided = 1'b1;
                  hit_in  = from_hit;
                  next_in = rd_data_ff.to_state;
               end
            end
            if (decided) begin
               done_in  = 1'b1;
               pend_in  = 1'b0;
               state_in = S_IDLE;
            end else if (idx_ff < limit_ff) begin
               idx_in  = idx_ff + 1'b1;
               pend_in = 1'b1;
            end else if (!pend_ff) begin
               done_in  = 1'b1;
               hit_in   = 1'b0;
               state_in = S_IDLE;
            end else begin
               pend_in = 1'b0;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_FROM;
         idx_ff   <= '0;
         limit_ff <= '0;
         pend_ff  <= 1'b0;
         sym_ff   <= '0;
         cur_ff   <= '0;
         done_ff  <= 1'b0;
         hit_ff   <= 1'b0;
         next_ff  <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         limit_ff <= limit_in;
         pend_ff  <= pend_in;
         sym_ff   <= sym_in;
         cur_ff   <= cur_in;
         done_ff  <= done_in;
         hit_ff   <= hit_in;
         next_ff  <= next_in;
      end
   end

   assign rsp.done       = done_ff;
   assign rsp.hit        = hit_ff;
   assign rsp.next_state = next_ff;

`ifndef NO_ASSERTIONS
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RUN |-> idx_ff <= limit_ff)
      else $error("scan index past limit");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("scan done held more than one cycle");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> state_ff == S_IDLE)
      else $error("scan started while busy");
`endif

endmodule

[rtl/rule_list_dfa_recognizer_top.sv]
// Rule list DFA recognizer: request/response handshake, DFA state, result register.
// Depends on rldr_pkg and rldr_scan.
`timescale 1ns / 1ps

// Usage:
//   Request channel (req_*): req_type selects load rule, input symbol or end of
//   string. A load writes req_rule_from/symbol/to into slot req_rule_index. A
//   symbol request starts a scan of the rule memory; the scan reads one rule
//   per cycle, and req_stall stays high after a symbol is accepted until the
//   scan is done. Symbols after a rejection start no scan and do not stall.
//   An end of string request produces one response in the next cycle and
//   resets the DFA to state 0.
//   Response channel (rsp_*): rsp_accepted and rsp_token_class sit in an output
//   register. While the receiver stalls it, all requests stall; the
//   register is freed in the cycle the response is taken.
//   csr_wr_en / csr_wr_data write rule_count; write only while idle.
//   Reset (synchronous, active high) clears the DFA state, rejection flag,
//   rule_count and the response valid. Rule memory contents are not cleared;
//   slots must be loaded before rule_count covers them.
module rule_list_dfa_recognizer_top #(
   parameter int RULE_DEPTH = rldr_pkg::RULE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [6:0] csr_wr_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_type,
   input  logic [5:0] req_rule_index,
   input  logic [7:0] req_rule_from,
   input  logic [7:0] req_rule_symbol,
   input  logic [7:0] req_rule_to,
   input  logic [7:0] req_symbol,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_accepted,
   output logic [6:0] rsp_token_class
);
   import rldr_pkg::*;

   typedef enum logic {T_IDLE, T_WAIT} state_type;

   state_type    state_ff, state_in;
   logic [7:0]   cur_state_ff, cur_state_in;
   logic         rejected_ff, rejected_in;
   logic [6:0]   rule_count_ff, rule_count_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         rsp_accepted_ff, rsp_accepted_in;
   logic [6:0]   rsp_token_class_ff, rsp_token_class_in;

   logic         req_accept, is_load, is_end, acc;
   rule_type     wr_rule;
   scan_cmd_type scan_cmd;
   scan_rsp_type scan_rsp;

   assign req_stall  = (state_ff != T_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;
   assign is_load    = req_accept && (req_type == REQ_LOAD);
   assign is_end     = req_accept && (req_type == REQ_END);
   assign acc        = !rejected_ff && cur_state_ff[ACCEPT_BIT];

   assign wr_rule.from_state = req_rule_from;
   assign wr_rule.symbol     = req_rule_symbol;
   assign wr_rule.to_state   = req_rule_to;

   assign scan_cmd.start      = req_accept && (req_type == REQ_SYMBOL) && !rejected_ff;
   assign scan_cmd.rule_count = rule_count_ff;
   assign scan_cmd.symbol     = req_symbol;
   assign scan_cmd.cur_state  = cur_state_ff;

   rldr_scan #(
      .RULE_DEPTH(RULE_DEPTH)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (is_load),
      .wr_index(req_rule_index),
      .wr_rule (wr_rule),
      .cmd     (scan_cmd),
      .rsp     (scan_rsp)
   );

   always_comb begin
      state_in           = state_ff;
      cur_state_in       = cur_state_ff;
      rejected_in        = rejected_ff;
      rule_count_in      = csr_wr_en ? csr_wr_data : rule_count_ff;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_accepted_in    = rsp_accepted_ff;
      rsp_token_class_in = rsp_token_class_ff;
      case (state_ff)
         T_IDLE: begin
            if (scan_cmd.start) begin
               state_in = T_WAIT;
            end
            if (is_end) begin
               rsp_valid_in       = 1'b1;
               rsp_accepted_in    = acc;
               rsp_token_class_in = acc ? cur_state_ff[6:0] : 7'd0;
               cur_state_in       = '0;
               rejected_in        = 1'b0;
            end
         end
         T_WAIT: begin
            if (scan_rsp.done) begin
               state_in = T_IDLE;
               if (scan_rsp.hit) begin
                  cur_state_in = scan_rsp.next_state;
               end else begin
                  rejected_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= T_IDLE;
         cur_state_ff       <= '0;
         rejected_ff        <= 1'b0;
         rule_count_ff      <= '0;
         rsp_valid_ff       <= 1'b0;
         rsp_accepted_ff    <= 1'b0;
         rsp_token_class_ff <= '0;
      end else begin
         state_ff           <= state_in;
         cur_state_ff       <= cur_state_in;
         rejected_ff        <= rejected_in;
         rule_count_ff      <= rule_count_in;
         rsp_valid_ff       <= rsp_valid_in;
         rsp_accepted_ff    <= rsp_accepted_in;
         rsp_token_class_ff <= rsp_token_class_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_accepted    = rsp_accepted_ff;
   assign rsp_token_class = rsp_token_class_ff;

`ifndef NO_ASSERTIONS
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      scan_rsp.done |-> state_ff == T_WAIT)
      else $error("scan result while not waiting");
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      is_end |=> rsp_valid_ff && cur_state_ff == 8'd0 && !rejected_ff)
      else $error("end of string did not clear state");
   a_reject_class: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_accepted_ff |-> rsp_token_class_ff == 7'd0)
      else $error("rejected response carries a class");
   a_start_wait: assert property (@(posedge clock) disable iff (reset)
      scan_cmd.start |=> state_ff == T_WAIT)
      else $error("symbol request did not start a scan");
`endif

endmodule
